/* rtl/ecspwm_pkg.sv */
// ----------------------------------------------------------------------------
// ecspwm_pkg
// Shared types, constants and helpers for the eight-channel servo PWM block.
// ----------------------------------------------------------------------------
package ecspwm_pkg;

	// Channel grouping and field widths
	localparam int GROUPS       = 2;
	localparam int CH_PER_GROUP = 4;
	localparam int SLOTS        = 8;
	localparam int GROUP_W      = 1;
	localparam int RATE_W       = 9;
	localparam int COUNT_W      = 16;
	localparam int PRESCALE_W   = 7;
	localparam int INDEX_W      = 4;
	localparam int TICKS_W      = PRESCALE_W + 1;

	// Rate limits and the one-second dividend for the period calculation
	localparam logic [RATE_W-1:0] RATE_MIN   = 9'd16;
	localparam logic [RATE_W-1:0] RATE_MAX   = 9'd500;
	localparam logic [RATE_W-1:0] RATE_RESET = 9'd50;
	localparam int US_PER_SECOND = 1000000;
	localparam int DIV_BITS      = 20;
	localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(US_PER_SECOND);
	localparam logic [COUNT_W-1:0] LIMIT_RESET =
		COUNT_W'(US_PER_SECOND / int'(RATE_RESET) - 1);

	// Defaults for the top-level parameters
	localparam int DEF_NUM_CHANNELS  = 8;
	localparam int DEF_TICKS_PER_US  = 72;
	localparam int DEF_INITIAL_PULSE = 1500;

	// Item operation codes
	typedef enum logic {
		MODE_TICK = 1'b0,
		MODE_SET  = 1'b1
	} mode_t;

	// Configuration write as seen by the internal units
	typedef struct packed {
		logic                we;
		logic [GROUP_W-1:0]  index;
		logic [RATE_W-1:0]   data;
	} cfg_wr_t;

	// One input item
	typedef struct packed {
		mode_t               mode;
		logic [INDEX_W-1:0]  servo_index;
		logic [COUNT_W-1:0]  pulse_width;
	} item_t;

	// One result item
	typedef struct packed {
		logic [SLOTS-1:0]    pwm_levels;
		logic                group_a_wrap;
		logic                group_b_wrap;
	} result_t;

	// Period limit update from the rate unit
	typedef struct packed {
		logic                valid;
		logic [GROUP_W-1:0]  group;
		logic [COUNT_W-1:0]  limit;
	} limit_upd_t;

	// Saturate a requested rate into the supported range
	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] rate);
		logic [RATE_W-1:0] r;
		r = rate;
		if (r < RATE_MIN) r = RATE_MIN;
		if (r > RATE_MAX) r = RATE_MAX;
		return r;
	endfunction

endpackage

/* rtl/ecspwm_cmd_if.sv */
// ----------------------------------------------------------------------------
// ecspwm_cmd_if
// Valid/ready channel carrying one tick or set-position item.
// ----------------------------------------------------------------------------
interface ecspwm_cmd_if
	import ecspwm_pkg::*;
();

	logic                valid;
	logic                ready;
	logic                mode;
	logic [INDEX_W-1:0]  servo_index;
	logic [COUNT_W-1:0]  pulse_width;

	modport source (output valid, output mode, output servo_index, output pulse_width,
		input ready);
	modport sink (input valid, input mode, input servo_index, input pulse_width,
		output ready);
endinterface

/* rtl/ecspwm_res_if.sv */
// ----------------------------------------------------------------------------
// ecspwm_res_if
// Valid/ready channel carrying one result item (levels and wrap flags).
// ----------------------------------------------------------------------------
interface ecspwm_res_if
	import ecspwm_pkg::*;
();

	logic                valid;
	logic                ready;
	logic [SLOTS-1:0]    pwm_levels;
	logic                group_a_wrap;
	logic                group_b_wrap;

	modport source (output valid, output pwm_levels, output group_a_wrap,
		output group_b_wrap, input ready);
	modport sink (input valid, input pwm_levels, input group_a_wrap,
		input group_b_wrap, output ready);
endinterface

/* rtl/ecspwm_rate.sv */
// ----------------------------------------------------------------------------
// ecspwm_rate
// Turns a rate register write into a period limit: 1000000 / rate - 1,
// worked out by a restoring divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ecspwm_rate
	import ecspwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_wr_t     cfg,
	output logic        busy,
	output limit_upd_t  upd
);

	localparam int CNT_W = $clog2(DIV_BITS);

	logic [GROUPS-1:0]   pend_q;
	logic [RATE_W-1:0]   rate_q [GROUPS];
	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [GROUP_W-1:0]  grp_q;
	logic [RATE_W-1:0]   div_q;
	logic [RATE_W-1:0]   rem_q;
	logic [COUNT_W-1:0]  quo_q;
	logic                upd_valid_q;
	logic [GROUP_W-1:0]  upd_grp_q;
	logic [COUNT_W-1:0]  upd_limit_q;

	logic                start;
	logic [GROUP_W-1:0]  start_grp;
	logic [GROUPS-1:0]   pend_nxt;
	logic [CNT_W-1:0]    bit_idx;
	logic                dbit;
	logic [RATE_W:0]     trial;
	logic                ge;
	logic [RATE_W-1:0]   rem_nxt;
	logic [COUNT_W-1:0]  quo_nxt;
	logic                last;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		start     = !busy_q && (|pend_q);
		start_grp = pend_q[0] ? GROUP_W'(0) : GROUP_W'(1);
		bit_idx   = CNT_W'(DIV_BITS - 1) - cnt_q;
		dbit      = DIVIDEND[bit_idx];
		trial     = {rem_q, dbit};
		ge        = trial >= {1'b0, div_q};
		rem_nxt   = ge ? RATE_W'(trial - {1'b0, div_q}) : trial[RATE_W-1:0];
		quo_nxt   = {quo_q[COUNT_W-2:0], ge};
		last      = cnt_q == CNT_W'(DIV_BITS - 1);
	end

	// Track groups waiting for a division; a new write wins over a start
	always_comb begin
		pend_nxt = pend_q;
		if (start) pend_nxt[start_grp] = 1'b0;
		if (cfg.we) pend_nxt[cfg.index] = 1'b1;
	end

	// Hold the clamped rate of each group until its division starts
	always_ff @(posedge clk) begin
		if (cfg.we) begin
			rate_q[cfg.index] <= clamp_rate(cfg.data);
		end
	end

	// Register the pending groups
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_nxt;
		end
	end

	// Sequence the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			upd_valid_q <= 1'b0;
		end else begin
			upd_valid_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last) busy_q <= 1'b0;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Advance remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= rate_q[start_grp];
			grp_q <= start_grp;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
			if (last) begin
				upd_grp_q   <= grp_q;
				upd_limit_q <= quo_nxt - COUNT_W'(1);
			end
		end
	end

	assign busy      = busy_q || (|pend_q);
	assign upd.valid = upd_valid_q;
	assign upd.group = upd_grp_q;
	assign upd.limit = upd_limit_q;

endmodule

/* rtl/ecspwm_core.sv */
// ----------------------------------------------------------------------------
// ecspwm_core
// Time bases, compare registers and output levels; applies one item per cycle
// while fire is high and no rate write is in; the result is combinational.
// ----------------------------------------------------------------------------
module ecspwm_core
	import ecspwm_pkg::*;
#(
	parameter int NUM_CHANNELS  = DEF_NUM_CHANNELS,
	parameter int TICKS_PER_US  = DEF_TICKS_PER_US,
	parameter int INITIAL_PULSE = DEF_INITIAL_PULSE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_wr_t     cfg,
	input  limit_upd_t  upd,
	input  logic        fire,
	input  item_t       item,
	output result_t     res
);

	localparam logic [TICKS_W-1:0]   TICKS = TICKS_W'(TICKS_PER_US);
	localparam logic [COUNT_W-1:0]   INIT  = COUNT_W'(INITIAL_PULSE);
	localparam logic [INDEX_W:0]     NCH   = (INDEX_W + 1)'(NUM_CHANNELS);

	logic [PRESCALE_W-1:0] prescale_q  [GROUPS];
	logic [COUNT_W-1:0]    period_q    [GROUPS];
	logic [COUNT_W-1:0]    limit_q     [GROUPS];
	logic [COUNT_W-1:0]    preload_q   [SLOTS];
	logic [COUNT_W-1:0]    active_q    [SLOTS];

	logic [PRESCALE_W-1:0] prescale_nxt [GROUPS];
	logic [COUNT_W-1:0]    period_nxt   [GROUPS];
	logic [COUNT_W-1:0]    active_nxt   [SLOTS];
	logic [GROUPS-1:0]     wrap;
	logic [SLOTS-1:0]      levels;
	logic                  tick;
	logic                  set_ok;

	// Advance both time bases on a tick item
	always_comb begin
		tick   = fire && (item.mode == MODE_TICK);
		set_ok = fire && (item.mode == MODE_SET) && ({1'b0, item.servo_index} < NCH);
		for (int g = 0; g < GROUPS; g++) begin
			prescale_nxt[g] = prescale_q[g];
			period_nxt[g]   = period_q[g];
			wrap[g]         = 1'b0;
			if (tick) begin
				if (({1'b0, prescale_q[g]} + TICKS_W'(1)) >= TICKS) begin
					prescale_nxt[g] = '0;
					if (period_q[g] >= limit_q[g]) begin
						period_nxt[g] = '0;
						wrap[g]       = 1'b1;
					end else begin
						period_nxt[g] = period_q[g] + COUNT_W'(1);
					end
				end else begin
					prescale_nxt[g] = prescale_q[g] + PRESCALE_W'(1);
				end
			end
		end
	end

	// Load preloads on wrap and compare against the new counter
	always_comb begin
		for (int c = 0; c < SLOTS; c++) begin
			active_nxt[c] = wrap[c / CH_PER_GROUP] ? preload_q[c] : active_q[c];
			levels[c]     = (c < NUM_CHANNELS) &&
				(period_nxt[c / CH_PER_GROUP] < active_nxt[c]);
		end
	end

	assign res.pwm_levels   = levels;
	assign res.group_a_wrap = wrap[0];
	assign res.group_b_wrap = wrap[1];

	// Update state: a rate write restarts its group, otherwise apply the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) begin
				prescale_q[g] <= '0;
				period_q[g]   <= '0;
				limit_q[g]    <= LIMIT_RESET;
			end
			for (int c = 0; c < SLOTS; c++) begin
				preload_q[c] <= INIT;
				active_q[c]  <= INIT;
			end
		end else begin
			if (upd.valid) limit_q[upd.group] <= upd.limit;
			if (cfg.we) begin
				prescale_q[cfg.index] <= '0;
				period_q[cfg.index]   <= '0;
				for (int c = 0; c < SLOTS; c++) begin
					if (GROUP_W'(c / CH_PER_GROUP) == cfg.index) active_q[c] <= preload_q[c];
				end
			end else if (fire) begin
				for (int g = 0; g < GROUPS; g++) begin
					prescale_q[g] <= prescale_nxt[g];
					period_q[g]   <= period_nxt[g];
				end
				for (int c = 0; c < SLOTS; c++) begin
					active_q[c] <= active_nxt[c];
				end
				if (set_ok) preload_q[item.servo_index[2:0]] <= item.pulse_width;
			end
		end
	end

endmodule

/* rtl/eight_channel_servo_pwm.sv */
// ----------------------------------------------------------------------------
// eight_channel_servo_pwm
// Eight RC servo PWM outputs in two groups of four, each group with its own
// 1 us time base and update rate.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per handshake: a tick (mode 0) advances both time
//   bases by one clock, a set-position item (mode 1) writes the preload
//   compare of servo_index; indexes at or above NUM_CHANNELS are dropped.
//   res returns exactly one result per item: the eight output levels after
//   the item and the wrap flag of each group.
//   Items pass the input register, then the result register; one item
//   is accepted every cycle while res keeps up and no rate write is pending.
//   When res stalls, the result register holds and the input register
//   fills; cmd.ready drops only once both are occupied.
//   A rate register write restarts the group's counters and loads its
//   compares at once; its period is found by a 20-step bit-serial divider,
//   and cmd.ready stays low from the write until that division ends (two
//   writes back to back are done one after the other).
//   Reset clears both pipeline stages, sets both groups to 50 Hz and every
//   compare to INITIAL_PULSE.
// ----------------------------------------------------------------------------
module eight_channel_servo_pwm
	import ecspwm_pkg::*;
#(
	parameter int NUM_CHANNELS  = DEF_NUM_CHANNELS,
	parameter int TICKS_PER_US  = DEF_TICKS_PER_US,
	parameter int INITIAL_PULSE = DEF_INITIAL_PULSE
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [GROUP_W-1:0]  cfg_index,
	input  logic [RATE_W-1:0]   cfg_data,
	ecspwm_cmd_if.sink          cmd,
	ecspwm_res_if.source        res
);

	item_t       item_s1;
	logic        valid_s1;
	result_t     result_s2;
	logic        valid_s2;

	cfg_wr_t     cfg;
	limit_upd_t  upd;
	logic        rate_busy;
	logic        s1_fire;
	logic        accept;
	result_t     core_res;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Move the held item forward whenever the result register is free
	assign s1_fire   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = (!valid_s1 || s1_fire) && !rate_busy && !cfg_we;
	assign accept    = cmd.valid && cmd.ready;

	ecspwm_rate u_rate (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.busy   (rate_busy),
		.upd    (upd)
	);

	ecspwm_core #(
		.NUM_CHANNELS  (NUM_CHANNELS),
		.TICKS_PER_US  (TICKS_PER_US),
		.INITIAL_PULSE (INITIAL_PULSE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.upd    (upd),
		.fire   (s1_fire),
		.item   (item_s1),
		.res    (core_res)
	);

	// Pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (s1_fire) valid_s1 <= 1'b0;
			if (s1_fire) valid_s2 <= 1'b1;
			else if (res.ready) valid_s2 <= 1'b0;
		end
	end

	// Capture the item and its result
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.mode        <= mode_t'(cmd.mode);
			item_s1.servo_index <= cmd.servo_index;
			item_s1.pulse_width <= cmd.pulse_width;
		end
		if (s1_fire) result_s2 <= core_res;
	end

	assign res.valid        = valid_s2;
	assign res.pwm_levels   = result_s2.pwm_levels;
	assign res.group_a_wrap = result_s2.group_a_wrap;
	assign res.group_b_wrap = result_s2.group_b_wrap;

`ifndef ASSERT_OFF
	// A result appears only from an item leaving the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(s1_fire))
		else $error("result appeared without an item");

	// No item enters while a period is being worked out
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !rate_busy)
		else $error("item accepted during period calculation");

	// A set-position item never reports a wrap
	a_set_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && (item_s1.mode == MODE_SET)) |=>
		(!result_s2.group_a_wrap && !result_s2.group_b_wrap))
		else $error("wrap flagged on a set-position item");
`endif

endmodule
